// ----- rtl/acpu_pkg.sv -----
// shared types, opcodes and fault codes for the accumulator cpu execute block
// no dependencies
`default_nettype none

package acpu_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned ADDR_W  = 8;
    localparam int unsigned INSTR_W = 16;
    localparam int unsigned MEM_DEPTH = 256;

    typedef enum logic [3:0] {
        OP_NOOP  = 4'h0,
        OP_ALUI  = 4'h1,
        OP_ALUM  = 4'h2,
        OP_CLAC  = 4'h3,
        OP_STORE = 4'h4,
        OP_BEQZ  = 4'h5,
        OP_HALT  = 4'hF
    } t_opcode;

    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_ALUSEL = 2'd1,
        FAULT_OPCODE = 2'd2
    } t_fault;

    localparam logic [3:0] SEL_ADD = 4'h0;
    localparam logic [3:0] SEL_SUB = 4'h1;

    localparam logic ACT_EXEC = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        logic              zero;
        logic              carry;
        logic              overflow;
    } t_alu_res;

endpackage

`default_nettype wire

// ----- rtl/acpu_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module acpu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/acpu_dmem.sv -----
// data memory: ram, per-byte valid bits for the zero reset, write-to-read forwarding
// depends on acpu_pkg and acpu_ram
`default_nettype none

module acpu_dmem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rd_en,
    input  wire logic [acpu_pkg::ADDR_W-1:0]   i_rd_addr,
    input  wire acpu_pkg::t_mem_wr             i_wr,
    output logic      [acpu_pkg::DATA_W-1:0]   o_rd_data
);

    logic [acpu_pkg::MEM_DEPTH-1:0] r_vld;
    logic                           r_rd_vld;
    logic                           r_fwd_hit;
    logic [acpu_pkg::DATA_W-1:0]    r_fwd_data;
    logic [acpu_pkg::DATA_W-1:0]    ram_rd_data;

    acpu_ram #(
        .WIDTH (acpu_pkg::DATA_W),
        .DEPTH (acpu_pkg::MEM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr.en),
        .i_wr_addr (i_wr.addr),
        .i_wr_data (i_wr.data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld  <= r_vld[i_rd_addr];
                r_fwd_hit <= i_wr.en && (i_wr.addr == i_rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr.data;
        end
    end

    always_comb begin
        if (r_fwd_hit) begin
            o_rd_data = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_data = ram_rd_data;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/acpu_alu.sv -----
// 8-bit add / subtract with zero, carry and overflow flags
// depends on acpu_pkg
`default_nettype none

module acpu_alu (
    input  wire logic [acpu_pkg::DATA_W-1:0] i_acc,
    input  wire logic [acpu_pkg::DATA_W-1:0] i_operand,
    input  wire logic                        i_sub,
    output acpu_pkg::t_alu_res               o_res
);

    logic [acpu_pkg::DATA_W-1:0] addend;
    logic [acpu_pkg::DATA_W:0]   sum;
    logic                        same_sign;

    always_comb begin
        addend    = i_sub ? (~i_operand + acpu_pkg::DATA_W'(1)) : i_operand;
        sum       = {1'b0, i_acc} + {1'b0, addend};
        same_sign = i_sub ? (i_acc[acpu_pkg::DATA_W-1] != i_operand[acpu_pkg::DATA_W-1])
                          : (i_acc[acpu_pkg::DATA_W-1] == i_operand[acpu_pkg::DATA_W-1]);
        o_res.acc      = sum[acpu_pkg::DATA_W-1:0];
        o_res.carry    = sum[acpu_pkg::DATA_W];
        o_res.zero     = (sum[acpu_pkg::DATA_W-1:0] == '0);
        o_res.overflow = same_sign &&
                         (sum[acpu_pkg::DATA_W-1] != i_acc[acpu_pkg::DATA_W-1]);
    end

endmodule

`default_nettype wire

// ----- rtl/accumulator_cpu_execute.sv -----
// top level of the accumulator cpu execute block: handshake, machine state, execute stage
// depends on acpu_pkg, acpu_dmem, acpu_alu
//
// usage
// - input channel: i_in_valid / o_in_stall; an item is taken at a rising edge with valid
//   high and stall low. i_action 0 executes i_instruction, 1 writes i_load_data to
//   data memory at i_load_address
// - output channel: o_out_valid / i_out_stall; one result item per input item, in order,
//   giving the fetch address, accumulator and flags after that item plus its fault code
// - sequence: the data memory read is issued at accept, the item then executes in the
//   execute stage and its result is registered in the result register when it fires
// - throughput: one item per cycle while i_out_stall is low; a store or load followed
//   directly by a memory add/sub to the same byte is forwarded, so no bubbles
// - stall: the result register holds while i_out_stall is high; one more item waits in
//   the execute stage, after which o_in_stall rises
// - reset (i_rst_n low, synchronous): pc, accumulator, flags and halted clear, all data
//   memory bytes read as zero at once (valid bit per byte), both channels empty
`default_nettype none

module accumulator_cpu_execute (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_action,
    input  wire logic [acpu_pkg::INSTR_W-1:0]       i_instruction,
    input  wire logic [acpu_pkg::ADDR_W-1:0]        i_load_address,
    input  wire logic [acpu_pkg::DATA_W-1:0]        i_load_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic      [acpu_pkg::ADDR_W-1:0]        o_fetch_address,
    output logic signed [acpu_pkg::DATA_W-1:0]      o_acc_value,
    output logic                                    o_zero_out,
    output logic                                    o_carry_out,
    output logic                                    o_overflow_out,
    output logic                                    o_halted_out,
    output logic      [1:0]                         o_fault
);

    // machine state
    logic [acpu_pkg::ADDR_W-1:0] r_pc,  n_pc;
    logic [acpu_pkg::DATA_W-1:0] r_acc, n_acc;
    logic                        r_z, n_z;
    logic                        r_c, n_c;
    logic                        r_v, n_v;
    logic                        r_halted, n_halted;
    acpu_pkg::t_fault            n_fault;

    // execute stage
    logic                         r_s1_valid;
    logic                         r_s1_action;
    logic [acpu_pkg::INSTR_W-1:0] r_s1_instr;
    logic [acpu_pkg::ADDR_W-1:0]  r_s1_laddr;
    logic [acpu_pkg::DATA_W-1:0]  r_s1_ldata;

    // result register
    logic                        r_out_valid;
    logic [acpu_pkg::ADDR_W-1:0] r_out_pc;
    logic [acpu_pkg::DATA_W-1:0] r_out_acc;
    logic                        r_out_z;
    logic                        r_out_c;
    logic                        r_out_v;
    logic                        r_out_halted;
    acpu_pkg::t_fault            r_out_fault;

    logic                        s1_fire;
    logic                        in_accept;
    acpu_pkg::t_opcode           opcode;
    logic [3:0]                  sel;
    logic [acpu_pkg::DATA_W-1:0] opnd;
    logic [acpu_pkg::DATA_W-1:0] mem_data;
    logic [acpu_pkg::DATA_W-1:0] alu_operand;
    acpu_pkg::t_alu_res          alu_res;
    acpu_pkg::t_mem_wr           mem_wr;
    logic                        exec_live;

    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign opcode    = acpu_pkg::t_opcode'(r_s1_instr[15:12]);
    assign sel       = r_s1_instr[11:8];
    assign opnd      = r_s1_instr[7:0];
    assign exec_live = (r_s1_action == acpu_pkg::ACT_EXEC) && !r_halted;

    acpu_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_addr (i_instruction[7:0]),
        .i_wr      (mem_wr),
        .o_rd_data (mem_data)
    );

    assign alu_operand = (opcode == acpu_pkg::OP_ALUM) ? mem_data : opnd;

    acpu_alu u_alu (
        .i_acc     (r_acc),
        .i_operand (alu_operand),
        .i_sub     (sel == acpu_pkg::SEL_SUB),
        .o_res     (alu_res)
    );

    always_comb begin
        mem_wr.en   = 1'b0;
        mem_wr.addr = opnd;
        mem_wr.data = r_acc;
        if (s1_fire) begin
            if (r_s1_action == acpu_pkg::ACT_LOAD) begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_s1_laddr;
                mem_wr.data = r_s1_ldata;
            end else if (exec_live && (opcode == acpu_pkg::OP_STORE)) begin
                mem_wr.en = 1'b1;
            end
        end
    end

    always_comb begin
        n_pc     = r_pc;
        n_acc    = r_acc;
        n_z      = r_z;
        n_c      = r_c;
        n_v      = r_v;
        n_halted = r_halted;
        n_fault  = acpu_pkg::FAULT_NONE;
        if (exec_live) begin
            n_pc = r_pc + acpu_pkg::ADDR_W'(1);
            case (opcode)
                acpu_pkg::OP_NOOP, acpu_pkg::OP_STORE: begin
                end
                acpu_pkg::OP_ALUI, acpu_pkg::OP_ALUM: begin
                    if ((sel == acpu_pkg::SEL_ADD) || (sel == acpu_pkg::SEL_SUB)) begin
                        n_acc = alu_res.acc;
                        n_z   = alu_res.zero;
                        n_c   = alu_res.carry;
                        n_v   = alu_res.overflow;
                    end else begin
                        n_fault = acpu_pkg::FAULT_ALUSEL;
                    end
                end
                acpu_pkg::OP_CLAC: begin
                    n_acc = '0;
                    n_z   = 1'b1;
                end
                acpu_pkg::OP_BEQZ: begin
                    if (r_z) begin
                        n_pc = opnd;
                    end
                end
                acpu_pkg::OP_HALT: begin
                    n_halted = 1'b1;
                end
                default: begin
                    n_halted = 1'b1;
                    n_fault  = acpu_pkg::FAULT_OPCODE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_acc       <= '0;
            r_z         <= 1'b0;
            r_c         <= 1'b0;
            r_v         <= 1'b0;
            r_halted    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_pc     <= n_pc;
                r_acc    <= n_acc;
                r_z      <= n_z;
                r_c      <= n_c;
                r_v      <= n_v;
                r_halted <= n_halted;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action <= i_action;
            r_s1_instr  <= i_instruction;
            r_s1_laddr  <= i_load_address;
            r_s1_ldata  <= i_load_data;
        end
        if (s1_fire) begin
            r_out_pc     <= n_pc;
            r_out_acc    <= n_acc;
            r_out_z      <= n_z;
            r_out_c      <= n_c;
            r_out_v      <= n_v;
            r_out_halted <= n_halted;
            r_out_fault  <= n_fault;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fetch_address = r_out_pc;
    assign o_acc_value     = r_out_acc;
    assign o_zero_out      = r_out_z;
    assign o_carry_out     = r_out_c;
    assign o_overflow_out  = r_out_v;
    assign o_halted_out    = r_out_halted;
    assign o_fault         = r_out_fault;

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// testbench for accumulator_cpu_execute: directed and random instruction streams with
// random idling on both channels, checked against an in-bench model of the machine
// depends on acpu_pkg and the accumulator_cpu_execute rtl
`timescale 1ns / 100ps

module tb_top;

    import acpu_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned PRINT_LIMIT = 50;

    typedef struct {
        logic [ADDR_W-1:0] pc;
        logic [DATA_W-1:0] acc;
        logic              zero;
        logic              carry;
        logic              overflow;
        logic              halted;
        t_fault            fault;
    } t_retire;

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_action      = ACT_EXEC;
    logic [INSTR_W-1:0]   in_instruction = '0;
    logic [ADDR_W-1:0]    in_load_address = '0;
    logic [DATA_W-1:0]    in_load_data   = '0;
    logic                 out_stall      = 1'b0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [ADDR_W-1:0]    o_fetch_address;
    logic [DATA_W-1:0]    o_acc_value;
    logic                 o_zero_out;
    logic                 o_carry_out;
    logic                 o_overflow_out;
    logic                 o_halted_out;
    logic [1:0]           o_fault;

    // machine state as the bench sees it
    logic [ADDR_W-1:0]    cpu_pc     = '0;
    logic [DATA_W-1:0]    cpu_acc    = '0;
    logic                 cpu_zero   = 1'b0;
    logic                 cpu_carry  = 1'b0;
    logic                 cpu_ovf    = 1'b0;
    logic                 cpu_halted = 1'b0;
    logic [DATA_W-1:0]    cpu_mem [0:MEM_DEPTH-1] = '{default: 8'h00};

    t_retire              retire_q[$];

    int                   mismatches  = 0;
    int                   quiet_cycles = 0;
    int                   stall_left  = 0;
    int                   sink_hold   = 0;
    bit                   src_gaps_on  = 1'b1;
    bit                   sink_gaps_on = 1'b1;

    accumulator_cpu_execute u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (in_action),
        .i_instruction   (in_instruction),
        .i_load_address  (in_load_address),
        .i_load_data     (in_load_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_fetch_address (o_fetch_address),
        .o_acc_value     (o_acc_value),
        .o_zero_out      (o_zero_out),
        .o_carry_out     (o_carry_out),
        .o_overflow_out  (o_overflow_out),
        .o_halted_out    (o_halted_out),
        .o_fault         (o_fault)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int draw_wait(input bit enabled);
        if (!enabled)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [INSTR_W-1:0] encode(input logic [3:0] op, input logic [3:0] sel,
                                                  input logic [7:0] opnd);
        return {op, sel, opnd};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_LIMIT)
            $display("tb: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // apply one accepted item to the machine state and queue the result it retires
    task automatic retire_item(input logic act, input logic [INSTR_W-1:0] word,
                               input logic [ADDR_W-1:0] la, input logic [DATA_W-1:0] ld);
        t_retire           r;
        logic [3:0]        op;
        logic [3:0]        sel;
        logic [7:0]        opnd;
        logic [7:0]        rhs;
        logic [7:0]        addend;
        logic [8:0]        sum;
        int                wide;
        op    = word[15:12];
        sel   = word[11:8];
        opnd  = word[7:0];
        r.fault = FAULT_NONE;
        if (act == ACT_LOAD) begin
            cpu_mem[la] = ld;
        end else if (!cpu_halted) begin
            cpu_pc = cpu_pc + 8'd1;
            case (op)
                OP_NOOP: ;
                OP_ALUI, OP_ALUM: begin
                    if (sel == SEL_ADD || sel == SEL_SUB) begin
                        rhs    = (op == OP_ALUI) ? opnd : cpu_mem[opnd];
                        addend = (sel == SEL_SUB) ? 8'd0 - rhs : rhs;
                        sum    = {1'b0, cpu_acc} + {1'b0, addend};
                        if (sel == SEL_SUB)
                            wide = int'($signed(cpu_acc)) - int'($signed(rhs));
                        else
                            wide = int'($signed(cpu_acc)) + int'($signed(rhs));
                        cpu_acc   = sum[7:0];
                        cpu_carry = sum[8];
                        cpu_ovf   = (wide < -128 || wide > 127);
                        cpu_zero  = (sum[7:0] == 8'd0);
                    end else begin
                        r.fault = FAULT_ALUSEL;
                    end
                end
                OP_CLAC: begin
                    cpu_acc  = '0;
                    cpu_zero = 1'b1;
                end
                OP_STORE: cpu_mem[opnd] = cpu_acc;
                OP_BEQZ: begin
                    if (cpu_zero)
                        cpu_pc = opnd;
                end
                OP_HALT: cpu_halted = 1'b1;
                default: begin
                    cpu_halted = 1'b1;
                    r.fault    = FAULT_OPCODE;
                end
            endcase
        end
        r.pc       = cpu_pc;
        r.acc      = cpu_acc;
        r.zero     = cpu_zero;
        r.carry    = cpu_carry;
        r.overflow = cpu_ovf;
        r.halted   = cpu_halted;
        retire_q.push_back(r);
    endtask

    task automatic send_item(input logic act, input logic [INSTR_W-1:0] word,
                             input logic [ADDR_W-1:0] la, input logic [DATA_W-1:0] ld);
        int gap;
        gap = draw_wait(src_gaps_on);
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid        <= 1'b1;
        in_action       <= act;
        in_instruction  <= word;
        in_load_address <= la;
        in_load_data    <= ld;
        do
            @(posedge i_clk);
        while (o_in_stall);
        retire_item(act, word, la, ld);
    endtask

    task automatic test_alu_immediate();
        send_item(ACT_EXEC, encode(OP_NOOP, SEL_ADD, 8'h00), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUI, SEL_ADD, 8'h7F), 8'hFF, 8'hFF);
        send_item(ACT_EXEC, encode(OP_ALUI, SEL_ADD, 8'h01), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUI, SEL_ADD, 8'hFF), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUI, SEL_SUB, 8'h7F), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUI, SEL_SUB, 8'h00), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUI, SEL_SUB, 8'h80), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUI, 4'hF, 8'h55), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUM, 4'h2, 8'hAA), 8'h00, 8'h00);
    endtask

    task automatic test_data_memory();
        send_item(ACT_LOAD, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(ACT_LOAD, 16'h0000, 8'h00, 8'h80);
        send_item(ACT_EXEC, encode(OP_ALUM, SEL_ADD, 8'hFF), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUM, SEL_SUB, 8'h00), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_STORE, SEL_ADD, 8'h10), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUM, SEL_ADD, 8'h10), 8'h00, 8'h00);
        send_item(ACT_LOAD, 16'h0000, 8'h20, 8'h01);
        send_item(ACT_EXEC, encode(OP_ALUM, SEL_SUB, 8'h20), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUM, SEL_ADD, 8'h33), 8'h00, 8'h00);
    endtask

    task automatic test_branch();
        send_item(ACT_EXEC, encode(OP_CLAC, SEL_ADD, 8'h00), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_BEQZ, SEL_ADD, 8'hFF), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_NOOP, SEL_ADD, 8'h00), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_ALUI, SEL_ADD, 8'h01), 8'h00, 8'h00);
        send_item(ACT_EXEC, encode(OP_BEQZ, SEL_ADD, 8'h40), 8'h00, 8'h00);
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        int n;
        src_gaps_on = 1'b0;
        sink_hold   = 80;
        for (n = 0; n < 16; n++)
            send_item(ACT_EXEC, encode(OP_ALUI, 4'($urandom_range(0, 1)), 8'($urandom)),
                      8'($urandom), 8'($urandom));
        src_gaps_on = 1'b1;
    endtask

    task automatic test_random_program(input int count);
        int          n;
        logic [3:0]  op;
        logic [3:0]  sel;
        logic [7:0]  addr;
        for (n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                src_gaps_on  = ($urandom_range(0, 3) != 0);
                sink_gaps_on = ($urandom_range(0, 3) != 0);
            end
            // a narrow window of addresses makes store/load then add/sub hits common
            addr = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            if ($urandom_range(0, 4) == 0) begin
                send_item(ACT_LOAD, 16'($urandom), addr, 8'($urandom));
            end else begin
                op  = 4'($urandom_range(0, 5));
                sel = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(2, 15))
                                                  : 4'($urandom_range(0, 1));
                send_item(ACT_EXEC, encode(op, sel, addr), 8'($urandom), 8'($urandom));
            end
        end
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    // halting is final, so it comes last; afterwards only loads change anything
    task automatic test_halt();
        int          n;
        logic [3:0]  op;
        op = ($urandom_range(0, 1) == 1) ? OP_HALT : 4'($urandom_range(6, 14));
        send_item(ACT_EXEC, encode(op, 4'($urandom), 8'($urandom)), 8'($urandom), 8'($urandom));
        for (n = 0; n < 30; n++)
            send_item(1'($urandom), 16'($urandom), 8'($urandom_range(0, 7)), 8'($urandom));
        for (n = 0; n < 4; n++)
            send_item(ACT_EXEC, encode(OP_ALUM, SEL_ADD, 8'(n)), 8'h00, 8'h00);
    endtask

    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                out_stall <= 1'b1;
                sink_hold--;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_retire r;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (retire_q.size() == 0) begin
                report_mismatch("result with nothing pending", o_fetch_address, 0);
            end else begin
                r = retire_q.pop_front();
                if (o_fetch_address !== r.pc)
                    report_mismatch("fetch_address", o_fetch_address, r.pc);
                if (o_acc_value !== r.acc)
                    report_mismatch("acc_value", o_acc_value, r.acc);
                if (o_zero_out !== r.zero)
                    report_mismatch("zero_out", o_zero_out, r.zero);
                if (o_carry_out !== r.carry)
                    report_mismatch("carry_out", o_carry_out, r.carry);
                if (o_overflow_out !== r.overflow)
                    report_mismatch("overflow_out", o_overflow_out, r.overflow);
                if (o_halted_out !== r.halted)
                    report_mismatch("halted_out", o_halted_out, r.halted);
                if (o_fault !== r.fault)
                    report_mismatch("fault", o_fault, r.fault);
            end
            stall_left = draw_wait(sink_gaps_on);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_alu_immediate();
        test_data_memory();
        test_branch();
        test_backpressure();
        test_random_program(700);
        test_halt();
        @(negedge i_clk);
        in_valid <= 1'b0;
        wait (retire_q.size() == 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/acpu_pkg.sv
rtl/acpu_ram.sv
rtl/acpu_dmem.sv
rtl/acpu_alu.sv
rtl/accumulator_cpu_execute.sv
dv/tb_top.sv
